// ===== sv/hidr_pkg.sv =====
// Package for the HID report reassembler: sizes, input kinds, length rules,
// status codes and register indexes.
// Depends on nothing; every other file of the block imports it.
package hidr_pkg;

  localparam int MAX_REPORT_BYTES = 64;
  localparam int IDX_W            = $clog2(MAX_REPORT_BYTES + 1);
  localparam int HDR_BYTES        = 7;
  localparam int HDR_LEN_LAST     = 6;
  localparam int HDR_MARKER_POS   = 2;
  localparam int HDR_LEN_FIRST    = 3;
  localparam int CFG_AW           = 4;
  localparam int CFG_DW           = 32;
  localparam int STALE_W          = 17;

  localparam logic [31:0] LEN_LIMIT   = 32'hFFFF_FFF9;
  localparam logic [31:0] LEN_EXTRA   = 32'd6;
  localparam logic [7:0]  SEQ_SKIP    = 8'hFF;
  localparam logic [7:0]  SEQ_LAST    = 8'hFE;
  localparam logic [7:0]  MARKER_A    = 8'h01;
  localparam logic [7:0]  MARKER_B    = 8'h03;
  localparam logic [15:0] STALE_RESET = 16'd4096;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] RULE_SINGLE = 2'd0;
  localparam logic [1:0] RULE_HEADER = 2'd1;
  localparam logic [1:0] RULE_ZERO   = 2'd2;
  localparam logic [1:0] RULE_UNDEF  = 2'd3;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_STALE     = 3'd2;
  localparam logic [2:0] ST_SEQUENCE  = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;
  localparam logic [2:0] ST_MARKER    = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;
  localparam logic [2:0] ST_EMPTY     = 3'd7;

  localparam logic [1:0] REG_COMMAND   = 2'd0;
  localparam logic [1:0] REG_RULE      = 2'd1;
  localparam logic [1:0] REG_MAX_STALE = 2'd2;

endpackage

// ===== sv/hidr_ifs.sv =====
// Channel interfaces of the HID report reassembler: report bytes in, packet bytes out.
// Depends on hidr_pkg.
interface hidr_in_if
  import hidr_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic       first_of_report;
  logic       last_of_report;

  modport source (output valid, kind, rx_byte, first_of_report, last_of_report, input ready);
  modport sink (input valid, kind, rx_byte, first_of_report, last_of_report, output ready);
endinterface

interface hidr_out_if
  import hidr_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] status;

  modport source (output valid, out_byte, byte_valid, status, input ready);
  modport sink (input valid, out_byte, byte_valid, status, output ready);
endinterface

// ===== sv/hid_report_reassembler.sv =====
// Top level of the HID report reassembler: input register, one pass of state update
// and a result register, plus the APB-style configuration registers.
// Depends on hidr_pkg and the channel interfaces in hidr_ifs.sv.
//
// The block takes one transaction per clock cycle while the output side is not stalled and
// gives exactly one result transaction for each, through the input and result registers. The
// sequence, stale-report and length checks are made in a single combinational pass between the
// input register and the result register, so that pass alone sets the rate of one item per cycle.
// A restart transaction clears all reception state but leaves the configuration registers.
module hid_report_reassembler
  import hidr_pkg::*;
  (
  input  logic              clk,
  input  logic              rst_n,
  hidr_in_if.sink           in_ch,
  hidr_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [7:0]  cmd_r;
  logic [1:0]  rule_r;
  logic [15:0] max_stale_r;

  logic        s1_v_r;
  logic [1:0]  s1_kind_r;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic        s1_last_r;

  logic        out_v_r;
  logic [7:0]  ob_r,  ob_nxt;
  logic        bv_r,  bv_nxt;
  logic [2:0]  st_r,  st_nxt;

  logic               active_r, active_nxt;
  logic               any_r, any_nxt;
  logic               first_rep_r, first_rep_nxt;
  logic               drop_r, drop_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic [STALE_W-1:0] stale_r, stale_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [31:0]        exp_r, exp_nxt;
  logic [31:0]        shift_r, shift_nxt;
  logic               marker_r, marker_nxt;

  logic               s2_free;
  logic               advance;
  logic [1:0]         rule;
  logic [IDX_W-1:0]   pos;
  logic               emit;
  logic               stale_hit;
  logic [31:0]        acc_base;
  logic [STALE_W-1:0] stale_inc;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= 8'd0;
      rule_r      <= RULE_HEADER;
      max_stale_r <= STALE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[CFG_AW-1:2])
        REG_COMMAND:   cmd_r       <= pwdata[7:0];
        REG_RULE:      rule_r      <= pwdata[1:0];
        REG_MAX_STALE: max_stale_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_COMMAND:   prdata = {24'd0, cmd_r};
      REG_RULE:      prdata = {30'd0, rule_r};
      REG_MAX_STALE: prdata = {16'd0, max_stale_r};
      default:       prdata = '0;
    endcase
  end

  assign s2_free     = !out_v_r || out_ch.ready;
  assign advance     = s1_v_r && s2_free;
  assign in_ch.ready = !s1_v_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_kind_r  <= in_ch.kind;
      s1_byte_r  <= in_ch.rx_byte;
      s1_first_r <= in_ch.first_of_report;
      s1_last_r  <= in_ch.last_of_report;
    end
  end

  assign rule      = (rule_r == RULE_UNDEF) ? RULE_ZERO : rule_r;
  assign stale_inc = (stale_r == {STALE_W{1'b1}}) ? stale_r : stale_r + STALE_W'(1);

  always_comb begin
    active_nxt    = active_r;
    any_nxt       = any_r;
    first_rep_nxt = first_rep_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    seq_nxt       = seq_r;
    stale_nxt     = stale_r;
    acc_nxt       = acc_r;
    exp_nxt       = exp_r;
    shift_nxt     = shift_r;
    marker_nxt    = marker_r;
    ob_nxt        = 8'd0;
    bv_nxt        = 1'b0;
    st_nxt        = ST_NONE;
    pos           = '0;
    emit          = 1'b0;
    stale_hit     = 1'b0;
    acc_base      = acc_r;
    if (advance) begin
      case (s1_kind_r)
        KIND_RESTART: begin
          active_nxt    = 1'b1;
          any_nxt       = 1'b0;
          first_rep_nxt = 1'b0;
          drop_nxt      = 1'b0;
          idx_nxt       = '0;
          seq_nxt       = 8'd0;
          stale_nxt     = '0;
          acc_nxt       = 32'd0;
          exp_nxt       = 32'd0;
          shift_nxt     = 32'd0;
          marker_nxt    = 1'b0;
        end
        KIND_EMPTY: begin
          if (active_r) begin
            st_nxt     = ST_EMPTY;
            active_nxt = 1'b0;
          end
        end
        KIND_BYTE: begin
          if (active_r) begin
            pos      = s1_first_r ? '0 : idx_r;
            drop_nxt = s1_first_r ? 1'b0 : drop_r;
            if (pos < IDX_W'(MAX_REPORT_BYTES)) begin
              idx_nxt = pos + IDX_W'(1);
              if (pos == '0) begin
                drop_nxt = 1'b0;
                if (!any_r) begin
                  if (s1_byte_r != 8'd0 || s1_last_r) begin
                    stale_hit = 1'b1;
                  end
                end else begin
                  first_rep_nxt = 1'b0;
                  if (s1_byte_r == SEQ_SKIP) begin
                    drop_nxt = 1'b1;
                  end else if (s1_byte_r != seq_r) begin
                    st_nxt     = ST_SEQUENCE;
                    active_nxt = 1'b0;
                  end else begin
                    seq_nxt = (seq_r >= SEQ_LAST) ? 8'd0 : seq_r + 8'd1;
                  end
                end
              end else if (!drop_nxt) begin
                if (!any_r) begin
                  if (s1_byte_r != cmd_r) begin
                    stale_hit = 1'b1;
                  end else begin
                    any_nxt       = 1'b1;
                    first_rep_nxt = 1'b1;
                    seq_nxt       = 8'd1;
                    acc_base      = 32'd0;
                    shift_nxt     = 32'd0;
                    marker_nxt    = 1'b0;
                    exp_nxt       = (rule == RULE_SINGLE) ? 32'd1 : 32'd0;
                    emit          = (rule == RULE_SINGLE) || (rule == RULE_HEADER);
                  end
                end else if (first_rep_r && rule == RULE_HEADER &&
                             pos <= IDX_W'(HDR_LEN_LAST)) begin
                  if (pos == IDX_W'(HDR_MARKER_POS)) begin
                    marker_nxt = !(s1_byte_r == MARKER_A || s1_byte_r == MARKER_B);
                  end else if (pos >= IDX_W'(HDR_LEN_FIRST)) begin
                    shift_nxt = {shift_r[23:0], s1_byte_r};
                  end
                  if (pos == IDX_W'(HDR_LEN_LAST)) begin
                    exp_nxt = (marker_nxt || shift_nxt > LEN_LIMIT) ? 32'd0
                                                                    : shift_nxt + LEN_EXTRA;
                  end
                  emit = 1'b1;
                end else begin
                  emit = acc_r < exp_r;
                end
                if (any_nxt) begin
                  if (emit) begin
                    ob_nxt = s1_byte_r;
                    bv_nxt = 1'b1;
                  end
                  acc_nxt = (acc_base == 32'hFFFF_FFFF) ? acc_base : acc_base + 32'd1;
                end
              end
            end
            if (stale_hit) begin
              drop_nxt  = 1'b1;
              stale_nxt = stale_inc;
              if (stale_inc > {1'b0, max_stale_r}) begin
                active_nxt = 1'b0;
                st_nxt     = ST_STALE;
              end
            end
            if (s1_last_r) begin
              if (active_nxt && any_nxt && !drop_nxt && st_nxt == ST_NONE) begin
                if (first_rep_nxt) begin
                  if (rule != RULE_SINGLE && idx_nxt < IDX_W'(HDR_BYTES)) begin
                    st_nxt = ST_SHORT;
                  end else if (rule == RULE_HEADER && marker_nxt) begin
                    st_nxt = ST_MARKER;
                  end else if (rule == RULE_HEADER && shift_nxt > LEN_LIMIT) begin
                    st_nxt = ST_OVERFLOW;
                  end
                end
                if (st_nxt == ST_NONE && acc_nxt >= exp_nxt) begin
                  st_nxt = ST_COMPLETE;
                end
                if (st_nxt != ST_NONE) begin
                  active_nxt = 1'b0;
                end
              end
              idx_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b1;
      any_r       <= 1'b0;
      first_rep_r <= 1'b0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      seq_r       <= 8'd0;
      stale_r     <= '0;
      acc_r       <= 32'd0;
      exp_r       <= 32'd0;
      shift_r     <= 32'd0;
      marker_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      any_r       <= any_nxt;
      first_rep_r <= first_rep_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      seq_r       <= seq_nxt;
      stale_r     <= stale_nxt;
      acc_r       <= acc_nxt;
      exp_r       <= exp_nxt;
      shift_r     <= shift_nxt;
      marker_r    <= marker_nxt;
      if (s2_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob_r <= ob_nxt;
      bv_r <= bv_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_byte   = ob_r;
  assign out_ch.byte_valid = bv_r;
  assign out_ch.status     = st_r;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while both stages are held");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !bv_r |-> ob_r == 8'd0)
    else $error("packet byte not zero without byte_valid");

  a_stop_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> out_v_r && st_r != ST_NONE)
    else $error("reception stopped without a status result");

  a_accept_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(any_r) |-> out_v_r)
    else $error("first report accepted without a result transaction");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for hid_report_reassembler: random and directed report streams checked against
// an in-bench reassembly predictor, under several register settings and idle patterns.
// Depends on hidr_pkg, the channel interfaces in hidr_ifs.sv and the block's RTL.
module testbench;
  import hidr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 140;
  localparam int WRAP_PHASE = 4;
  localparam int WRAP_REPORTS = 260;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int PH_CMD [N_PHASES] = '{8'hA5, 8'hFF, 8'h00, 8'h3C, 8'h81, 8'h00, 8'hFF, 8'h5A};
  localparam int PH_RULE [N_PHASES] = '{RULE_HEADER, RULE_SINGLE, RULE_ZERO, RULE_UNDEF,
                                         RULE_HEADER, RULE_HEADER, RULE_HEADER, RULE_HEADER};
  localparam int PH_STALE [N_PHASES] = '{2, 65535, 0, 1, 4096, 65535, 0, 3};
  localparam int PH_IDLE [N_PHASES] = '{0, 65, 0, 24, 0, 65, 0, 24};
  localparam int PH_STALL [N_PHASES] = '{0, 0, 65, 24, 0, 0, 65, 24};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       first_of_report;
    logic       last_of_report;
  } rpt_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
  } pkt_out_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  hidr_in_if in_ch ();
  hidr_out_if out_ch ();

  hid_report_reassembler dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  rpt_item_t report_stream[$];
  pkt_out_t packet_outputs_due[$];
  rpt_item_t on_wire;
  pkt_out_t got;
  pkt_out_t want;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  logic out_hold;
  int unsigned mismatches;
  int unsigned results_seen;

  logic [7:0] cmd_reg;
  logic [1:0] rule_reg;
  logic [15:0] max_stale_reg;

  logic rx_active;
  logic rx_accepted;
  logic in_first_rpt;
  logic skip_rpt;
  logic [6:0] rpt_pos;
  logic [7:0] seq_due;
  logic [16:0] stale_seen;
  logic [31:0] pkt_count;
  logic [31:0] pkt_len;
  logic [31:0] hdr_len_acc;
  logic hdr_marker_bad;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_reception();
    rx_active = 1'b1;
    rx_accepted = 1'b0;
    in_first_rpt = 1'b0;
    skip_rpt = 1'b0;
    rpt_pos = '0;
    seq_due = '0;
    stale_seen = '0;
    pkt_count = '0;
    pkt_len = '0;
    hdr_len_acc = '0;
    hdr_marker_bad = 1'b0;
  endfunction

  function automatic logic [2:0] count_stale();
    skip_rpt = 1'b1;
    if (stale_seen != '1) stale_seen = stale_seen + 1'b1;
    if (stale_seen > {1'b0, max_stale_reg}) begin
      rx_active = 1'b0;
      return ST_STALE;
    end
    return ST_NONE;
  endfunction

  function automatic pkt_out_t reassemble_step(input rpt_item_t it);
    pkt_out_t r;
    logic [1:0] rule;
    int unsigned pos;
    logic emit;
    r = '0;
    emit = 1'b0;
    rule = (rule_reg == RULE_UNDEF) ? RULE_ZERO : rule_reg;
    if (it.kind == KIND_RESTART) begin
      clear_reception();
    end else if (it.kind == KIND_EMPTY && rx_active) begin
      r.status = ST_EMPTY;
      rx_active = 1'b0;
    end else if (it.kind == KIND_BYTE && rx_active) begin
      if (it.first_of_report) begin
        rpt_pos = '0;
        skip_rpt = 1'b0;
      end
      pos = rpt_pos;
      if (pos < MAX_REPORT_BYTES) begin
        rpt_pos = 7'(pos + 1);
        if (pos == 0) begin
          skip_rpt = 1'b0;
          if (!rx_accepted) begin
            if (it.rx_byte != 8'd0 || it.last_of_report) r.status = count_stale();
          end else begin
            in_first_rpt = 1'b0;
            if (it.rx_byte == SEQ_SKIP) begin
              skip_rpt = 1'b1;
            end else if (it.rx_byte != seq_due) begin
              r.status = ST_SEQUENCE;
              rx_active = 1'b0;
            end else begin
              seq_due = (seq_due >= SEQ_LAST) ? 8'd0 : seq_due + 8'd1;
            end
          end
        end else if (!skip_rpt) begin
          if (!rx_accepted) begin
            if (it.rx_byte != cmd_reg) begin
              r.status = count_stale();
            end else begin
              rx_accepted = 1'b1;
              in_first_rpt = 1'b1;
              seq_due = 8'd1;
              pkt_count = '0;
              hdr_len_acc = '0;
              hdr_marker_bad = 1'b0;
              pkt_len = (rule == RULE_SINGLE) ? 32'd1 : 32'd0;
              emit = (rule == RULE_HEADER) || (pkt_count < pkt_len);
            end
          end else if (in_first_rpt && rule == RULE_HEADER && pos <= HDR_LEN_LAST) begin
            if (pos == HDR_MARKER_POS) begin
              hdr_marker_bad = !(it.rx_byte == MARKER_A || it.rx_byte == MARKER_B);
            end else if (pos >= HDR_LEN_FIRST) begin
              hdr_len_acc = {hdr_len_acc[23:0], it.rx_byte};
            end
            if (pos == HDR_LEN_LAST) begin
              pkt_len = (hdr_marker_bad || hdr_len_acc > LEN_LIMIT) ? 32'd0
                                                                    : hdr_len_acc + LEN_EXTRA;
            end
            emit = 1'b1;
          end else begin
            emit = pkt_count < pkt_len;
          end
          if (rx_accepted) begin
            if (emit) begin
              r.out_byte = it.rx_byte;
              r.byte_valid = 1'b1;
            end
            if (pkt_count != '1) pkt_count = pkt_count + 1;
          end
        end
      end
      if (it.last_of_report) begin
        if (rx_active && rx_accepted && !skip_rpt && r.status == ST_NONE) begin
          if (in_first_rpt) begin
            if (rule != RULE_SINGLE && rpt_pos < HDR_BYTES) begin
              r.status = ST_SHORT;
            end else if (rule == RULE_HEADER && hdr_marker_bad) begin
              r.status = ST_MARKER;
            end else if (rule == RULE_HEADER && hdr_len_acc > LEN_LIMIT) begin
              r.status = ST_OVERFLOW;
            end
          end
          if (r.status == ST_NONE && pkt_count >= pkt_len) r.status = ST_COMPLETE;
          if (r.status != ST_NONE) rx_active = 1'b0;
        end
        rpt_pos = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) packet_outputs_due.push_back(reassemble_step(on_wire));
      if (!in_ch.valid || in_ch.ready) begin
        if (report_stream.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          on_wire = report_stream.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= on_wire.kind;
          in_ch.rx_byte <= on_wire.rx_byte;
          in_ch.first_of_report <= on_wire.first_of_report;
          in_ch.last_of_report <= on_wire.last_of_report;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.out_byte = out_ch.out_byte;
        got.byte_valid = out_ch.byte_valid;
        got.status = out_ch.status;
        if (packet_outputs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d arrived with nothing pending: byte %02h valid %0b status %0d",
                     results_seen, got.out_byte, got.byte_valid, got.status);
          end
        end else begin
          want = packet_outputs_due.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected byte %02h valid %0b status %0d, got byte %02h valid %0b status %0d",
                       results_seen, want.out_byte, want.byte_valid, want.status,
                       got.out_byte, got.byte_valid, got.status);
            end
          end
        end
      end
      out_ch.ready <= !out_hold && ($urandom_range(99) >= out_stall_pct);
    end
  end

  function automatic void push_ctl(input logic [1:0] k);
    rpt_item_t it;
    it.kind = k;
    it.rx_byte = 8'($urandom);
    it.first_of_report = 1'($urandom);
    it.last_of_report = 1'($urandom);
    report_stream.push_back(it);
  endfunction

  function automatic void add_report(input byte_q_t body, input bit ends, input bit tidy);
    rpt_item_t it;
    for (int i = 0; i < body.size(); i++) begin
      it.kind = KIND_BYTE;
      it.rx_byte = body[i];
      it.first_of_report = (i == 0) && (tidy || $urandom_range(19) != 0);
      it.last_of_report = ends && (i == body.size() - 1);
      report_stream.push_back(it);
    end
  endfunction

  function automatic void queue_reception();
    byte_q_t rpt;
    int roll;
    int keep;
    int len;
    int n_stale;
    int n_rpts;
    logic [31:0] hdr_len;
    logic [7:0] mark;
    logic [7:0] seq;
    longint need;
    longint have;
    bit ends;
    push_ctl(KIND_RESTART);
    n_stale = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n_stale) begin
      rpt = {};
      roll = $urandom_range(2);
      if (roll == 0) begin
        rpt.push_back(8'($urandom_range(1, 255)));
      end else begin
        rpt.push_back(8'h00);
        if (roll == 2) rpt.push_back(cmd_reg ^ 8'($urandom_range(1, 255)));
      end
      if (roll != 1) repeat ($urandom_range(0, 4)) rpt.push_back(8'($urandom));
      add_report(rpt, 1'b1, 1'b0);
    end
    rpt = {8'h00, cmd_reg};
    need = (rule_reg == RULE_SINGLE) ? 1 : 0;
    if (rule_reg == RULE_HEADER) begin
      if ($urandom_range(99) < 8) begin
        do mark = 8'($urandom); while (mark == MARKER_A || mark == MARKER_B);
      end else begin
        mark = $urandom_range(1) ? MARKER_A : MARKER_B;
      end
      rpt.push_back(mark);
      roll = $urandom_range(99);
      if (roll < 6) hdr_len = LEN_LIMIT + 32'($urandom_range(1, 6));
      else if (roll < 9) hdr_len = $urandom;
      else hdr_len = $urandom_range(0, 40);
      for (int i = 3; i >= 0; i--) rpt.push_back(hdr_len[8*i +: 8]);
      need = longint'(hdr_len) + 6;
    end
    repeat ($urandom_range(0, 8)) rpt.push_back(8'($urandom));
    if ($urandom_range(99) < 6) begin
      keep = $urandom_range(2, 6);
      while (rpt.size() > keep) void'(rpt.pop_back());
    end
    add_report(rpt, 1'b1, 1'b0);
    have = rpt.size() - 1;
    seq = 8'd1;
    n_rpts = 0;
    while (have < need && n_rpts < 12) begin
      n_rpts++;
      roll = $urandom_range(99);
      if (roll < 3) begin
        push_ctl(KIND_EMPTY);
        break;
      end else if (roll < 5) begin
        push_ctl(KIND_UNUSED);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 12);
        rpt = {};
        if (roll < 12) rpt.push_back(SEQ_SKIP);
        else if (roll < 15) rpt.push_back(seq + 8'($urandom_range(1, 250)));
        else rpt.push_back(seq);
        repeat (len - 1) rpt.push_back(8'($urandom));
        ends = $urandom_range(19) != 0;
        add_report(rpt, ends, 1'b0);
        if (roll >= 15) begin
          have += ((len > MAX_REPORT_BYTES) ? MAX_REPORT_BYTES : len) - 1;
          seq = (seq == SEQ_LAST) ? 8'd0 : seq + 8'd1;
        end
      end
    end
    repeat ($urandom_range(0, 2)) push_ctl(2'($urandom_range(0, 3)));
  endfunction

  function automatic void queue_long_packet();
    byte_q_t rpt;
    logic [7:0] seq;
    push_ctl(KIND_RESTART);
    rpt = {8'h00, cmd_reg, MARKER_A, 8'h00, 8'h00, 8'h01, 8'h04};
    add_report(rpt, 1'b1, 1'b1);
    seq = 8'd1;
    repeat (WRAP_REPORTS) begin
      rpt = {seq, 8'($urandom)};
      add_report(rpt, 1'b1, 1'b1);
      seq = (seq == SEQ_LAST) ? 8'd0 : seq + 8'd1;
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COMMAND: cmd_reg = val[7:0];
      REG_RULE: rule_reg = val[1:0];
      REG_MAX_STALE: max_stale_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (report_stream.size() != 0 || in_ch.valid || packet_outputs_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    #3_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    byte_q_t rpt;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_BYTE;
    in_ch.rx_byte = '0;
    in_ch.first_of_report = 1'b0;
    in_ch.last_of_report = 1'b0;
    out_ch.ready = 1'b0;
    out_hold = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    mismatches = 0;
    results_seen = 0;
    cmd_reg = 8'd0;
    rule_reg = RULE_HEADER;
    max_stale_reg = STALE_RESET;
    clear_reception();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_ctl(KIND_UNUSED);
    rpt = {8'h07};
    add_report(rpt, 1'b1, 1'b1);
    rpt = {8'h00, 8'h5A};
    add_report(rpt, 1'b1, 1'b1);
    rpt = {8'h00, 8'h00, MARKER_B, 8'h00, 8'h00, 8'h00, 8'h03};
    add_report(rpt, 1'b1, 1'b1);
    rpt = {SEQ_SKIP, 8'h12};
    add_report(rpt, 1'b1, 1'b1);
    rpt = {8'h01, 8'h80, 8'h7F, 8'h55};
    add_report(rpt, 1'b1, 1'b1);
    push_ctl(KIND_EMPTY);
    push_ctl(KIND_RESTART);
    rpt = {8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    add_report(rpt, 1'b1, 1'b1);
    wait_drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_COMMAND, PH_CMD[p]);
      write_reg(REG_RULE, PH_RULE[p]);
      write_reg(REG_MAX_STALE, PH_STALE[p]);
      @(negedge clk);
      in_idle_pct = PH_IDLE[p];
      out_stall_pct = PH_STALL[p];
      if (p == WRAP_PHASE) queue_long_packet();
      while (report_stream.size() < PHASE_ITEMS) queue_reception();
      if (p == 0) begin
        out_hold = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_hold = 1'b0;
      end
      wait_drain();
    end

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hidr_pkg.sv
sv/hidr_ifs.sv
sv/hid_report_reassembler.sv
sim/testbench.sv
